FILE: hdl/cda_pkg.sv
// Shared types, constants, microcode table and calendar helpers for the date adder.
package cda_pkg;

  localparam int YEAR_BITS = 16;
  localparam int MONTH_SUM_BITS = 17;
  localparam int DIV_W = (YEAR_BITS > MONTH_SUM_BITS) ? YEAR_BITS : MONTH_SUM_BITS;
  localparam int DCNT_W = 1;
  localparam int REM_W = 9;
  localparam int UPC_W = 4;

  typedef logic [YEAR_BITS-1:0] year_t;
  typedef logic [DIV_W-1:0] div_t;
  typedef logic [REM_W-1:0] rem_t;
  typedef logic [DCNT_W-1:0] dcnt_t;
  typedef logic [UPC_W-1:0] upc_t;

  localparam rem_t DIVISOR_MONTH = rem_t'(12);
  localparam rem_t DIVISOR_YEAR = rem_t'(400);
  localparam rem_t CENTURY = rem_t'(100);
  localparam dcnt_t DIV_LAST = dcnt_t'(1);

  // Reciprocals of the odd factors 3 and 25, scaled by 2^16. After the power of two
  // is shifted off, they are exact for month sums up to 2^17 and years up to 2^16.
  localparam int RECIP_W = 15;
  localparam int RECIP_SHIFT = 16;
  localparam int MONTH_PRE_SHIFT = 2;
  localparam int YEAR_PRE_SHIFT = 4;
  localparam logic [RECIP_W-1:0] RECIP_MONTH = 15'd21846;
  localparam logic [RECIP_W-1:0] RECIP_YEAR = 15'd2622;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_DAYS,
    KIND_MONTHS,
    KIND_YEARS
  } kind_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DAY_STEP,
    OP_DIV_MONTH,
    OP_DIV_YEAR,
    OP_DIV_STEP,
    OP_MONTH_WB,
    OP_RES_WB,
    OP_YEAR_ADD,
    OP_PUBLISH
  } uop_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_DISPATCH,
    C_CNT_GT1,
    C_DIV_MORE,
    C_OUT_FULL
  } ucond_e;

  typedef struct packed {
    uop_e   op;
    ucond_e cond;
    upc_t   br;
    upc_t   nxt;
  } uword_t;

  typedef struct packed {
    logic cnt_gt1;
    logic div_more;
    logic out_full;
  } ustat_t;

  typedef struct packed {
    logic start;
    logic step;
    logic sel_year;
  } div_ctl_t;

  localparam upc_t UPC_IDLE    = upc_t'(0);
  localparam upc_t UPC_LOAD    = upc_t'(1);
  localparam upc_t UPC_DAYS    = upc_t'(2);
  localparam upc_t UPC_MON     = upc_t'(3);
  localparam upc_t UPC_MON_RUN = upc_t'(4);
  localparam upc_t UPC_MON_WB  = upc_t'(5);
  localparam upc_t UPC_YMOD    = upc_t'(6);
  localparam upc_t UPC_YMOD_RUN = upc_t'(7);
  localparam upc_t UPC_YMOD_WB = upc_t'(8);
  localparam upc_t UPC_PUB     = upc_t'(9);
  localparam upc_t UPC_YEARS   = upc_t'(10);

  // Control store. A true condition takes the branch target, otherwise the next field.
  function automatic uword_t urom(upc_t addr);
    uword_t w;
    unique case (addr)
      UPC_IDLE:     w = '{OP_NOP,       C_DISPATCH, UPC_IDLE,     UPC_IDLE};
      UPC_LOAD:     w = '{OP_LOAD,      C_NEVER,    UPC_IDLE,     UPC_YMOD};
      UPC_DAYS:     w = '{OP_DAY_STEP,  C_CNT_GT1,  UPC_DAYS,     UPC_PUB};
      UPC_MON:      w = '{OP_DIV_MONTH, C_NEVER,    UPC_IDLE,     UPC_MON_RUN};
      UPC_MON_RUN:  w = '{OP_DIV_STEP,  C_DIV_MORE, UPC_MON_RUN,  UPC_MON_WB};
      UPC_MON_WB:   w = '{OP_MONTH_WB,  C_NEVER,    UPC_IDLE,     UPC_YMOD};
      UPC_YMOD:     w = '{OP_DIV_YEAR,  C_NEVER,    UPC_IDLE,     UPC_YMOD_RUN};
      UPC_YMOD_RUN: w = '{OP_DIV_STEP,  C_DIV_MORE, UPC_YMOD_RUN, UPC_YMOD_WB};
      UPC_YMOD_WB:  w = '{OP_RES_WB,    C_NEVER,    UPC_IDLE,     UPC_PUB};
      UPC_PUB:      w = '{OP_PUBLISH,   C_OUT_FULL, UPC_PUB,      UPC_IDLE};
      UPC_YEARS:    w = '{OP_YEAR_ADD,  C_NEVER,    UPC_IDLE,     UPC_YMOD};
      default:      w = '{OP_NOP,       C_NEVER,    UPC_IDLE,     UPC_IDLE};
    endcase
    return w;
  endfunction

  function automatic upc_t entry(kind_e k);
    upc_t a;
    unique case (k)
      KIND_LOAD:   a = UPC_LOAD;
      KIND_DAYS:   a = UPC_DAYS;
      KIND_MONTHS: a = UPC_MON;
      KIND_YEARS:  a = UPC_YEARS;
      default:     a = UPC_IDLE;
    endcase
    return a;
  endfunction

  // The leap rule only needs the year modulo 400.
  function automatic logic leap_from_res(rem_t r);
    return (r[1:0] == 2'b00) && (r != CENTURY) && (r != rem_t'(2 * 100))
        && (r != rem_t'(3 * 100));
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] len;
    case (m) inside
      MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      default:                                    len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: hdl/cda_cdiv.sv
// Divider by a constant (12 or 400) by reciprocal multiplication: quotient, then remainder.
module cda_cdiv (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cda_pkg::div_ctl_t   ctl_i,
  input  cda_pkg::div_t       dividend_i,
  output cda_pkg::div_t       quot_o,
  output cda_pkg::rem_t       rem_o,
  output logic                more_o
);

  cda_pkg::div_t  x_q, x_d;
  cda_pkg::div_t  quot_q, quot_d;
  cda_pkg::rem_t  rem_q, rem_d;
  cda_pkg::rem_t  divisor_q, divisor_d;
  logic           sel_year_q, sel_year_d;
  cda_pkg::dcnt_t cnt_q, cnt_d;

  logic [cda_pkg::RECIP_W-1:0]   mul_a;
  logic [cda_pkg::RECIP_W-1:0]   mul_b;
  logic [2*cda_pkg::RECIP_W-1:0] prod;
  cda_pkg::div_t                 back;
  cda_pkg::div_t                 diff;

  // 12 = 4 * 3 and 400 = 16 * 25: the power of two is shifted off first.
  assign mul_a = sel_year_q ? cda_pkg::RECIP_W'(x_q >> cda_pkg::YEAR_PRE_SHIFT)
                            : cda_pkg::RECIP_W'(x_q >> cda_pkg::MONTH_PRE_SHIFT);
  assign mul_b = sel_year_q ? cda_pkg::RECIP_YEAR : cda_pkg::RECIP_MONTH;
  assign prod  = {{cda_pkg::RECIP_W{1'b0}}, mul_a} * {{cda_pkg::RECIP_W{1'b0}}, mul_b};
  assign back  = quot_q * cda_pkg::div_t'(divisor_q);
  assign diff  = x_q - back;

  always_comb begin
    x_d        = x_q;
    quot_d     = quot_q;
    rem_d      = rem_q;
    divisor_d  = divisor_q;
    sel_year_d = sel_year_q;
    cnt_d      = cnt_q;
    if (ctl_i.start) begin
      x_d        = dividend_i;
      rem_d      = '0;
      sel_year_d = ctl_i.sel_year;
      divisor_d  = ctl_i.sel_year ? cda_pkg::DIVISOR_YEAR : cda_pkg::DIVISOR_MONTH;
      cnt_d      = cda_pkg::DIV_LAST;
    end else if (ctl_i.step) begin
      if (cnt_q != '0) begin
        quot_d = cda_pkg::div_t'(prod >> cda_pkg::RECIP_SHIFT);
        cnt_d  = cnt_q - cda_pkg::dcnt_t'(1);
      end else begin
        rem_d = cda_pkg::rem_t'(diff);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q      <= '0;
      divisor_q  <= cda_pkg::DIVISOR_MONTH;
      sel_year_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      rem_q      <= rem_d;
      divisor_q  <= divisor_d;
      sel_year_q <= sel_year_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    quot_q <= quot_d;
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q;
  assign more_o = cnt_q != '0;

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q < divisor_q) else $error("divider remainder not below divisor");
`endif

endmodule

FILE: hdl/cda_dpath.sv
// Date registers, day counter and year-mod-400 residue driven by the micro-op.
module cda_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_fire_i,
  input  logic [15:0]         amount_i,
  input  logic [4:0]          load_day_i,
  input  logic [3:0]          load_month_i,
  input  logic [15:0]         load_year_i,
  input  cda_pkg::uop_e       op_i,
  input  cda_pkg::div_t       quot_i,
  input  cda_pkg::rem_t       rem_i,
  output cda_pkg::div_t       dividend_o,
  output logic                cnt_gt1_o,
  output logic [4:0]          day_o,
  output logic [3:0]          month_o,
  output cda_pkg::year_t      year_o
);

  logic [4:0]     day_q, day_d;
  logic [3:0]     month_q, month_d;
  cda_pkg::year_t year_q, year_d;
  cda_pkg::rem_t  res_q, res_d;
  logic [15:0]    amt_q, amt_d;
  logic [4:0]     ld_day_q;
  logic [3:0]     ld_month_q;
  logic [15:0]    ld_year_q;

  logic [4:0]                           mlen;
  logic [cda_pkg::MONTH_SUM_BITS-1:0]   month_sum;

  assign mlen      = cda_pkg::month_len(month_q, cda_pkg::leap_from_res(res_q));
  assign month_sum = cda_pkg::MONTH_SUM_BITS'(month_q - 4'd1)
                   + cda_pkg::MONTH_SUM_BITS'(amt_q);

  always_comb begin
    dividend_o = cda_pkg::div_t'(year_q);
    if (op_i == cda_pkg::OP_DIV_MONTH) begin
      dividend_o = cda_pkg::div_t'(month_sum);
    end
  end

  always_comb begin
    day_d   = day_q;
    month_d = month_q;
    year_d  = year_q;
    res_d   = res_q;
    amt_d   = amt_q;
    if (in_fire_i) begin
      amt_d = amount_i;
    end
    case (op_i)
      cda_pkg::OP_LOAD: begin
        day_d = (ld_day_q == 5'd0) ? 5'd1 : ld_day_q;
        if (ld_month_q == 4'd0) begin
          month_d = cda_pkg::MONTH_JAN;
        end else if (ld_month_q > cda_pkg::MONTH_DEC) begin
          month_d = cda_pkg::MONTH_DEC;
        end else begin
          month_d = ld_month_q;
        end
        year_d = cda_pkg::year_t'(ld_year_q);
      end
      cda_pkg::OP_DAY_STEP: begin
        if (amt_q != 16'd0) begin
          amt_d = amt_q - 16'd1;
          if (day_q >= mlen) begin
            day_d = 5'd1;
            if (month_q >= cda_pkg::MONTH_DEC) begin
              month_d = cda_pkg::MONTH_JAN;
              year_d  = year_q + cda_pkg::year_t'(1);
              // Keep the residue in step so the next day sees the right leap flag;
              // a wrapping year starts again at residue zero.
              if (year_q == '1
                  || res_q == cda_pkg::DIVISOR_YEAR - cda_pkg::rem_t'(1)) begin
                res_d = '0;
              end else begin
                res_d = res_q + cda_pkg::rem_t'(1);
              end
            end else begin
              month_d = month_q + 4'd1;
            end
          end else begin
            day_d = day_q + 5'd1;
          end
        end
      end
      cda_pkg::OP_MONTH_WB: begin
        month_d = rem_i[3:0] + 4'd1;
        year_d  = year_q + cda_pkg::year_t'(quot_i);
      end
      cda_pkg::OP_RES_WB: begin
        res_d = rem_i;
      end
      cda_pkg::OP_YEAR_ADD: begin
        year_d = year_q + cda_pkg::year_t'(amt_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_q   <= 5'd1;
      month_q <= cda_pkg::MONTH_JAN;
      year_q  <= '0;
      res_q   <= '0;
      amt_q   <= '0;
    end else begin
      day_q   <= day_d;
      month_q <= month_d;
      year_q  <= year_d;
      res_q   <= res_d;
      amt_q   <= amt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      ld_day_q   <= load_day_i;
      ld_month_q <= load_month_i;
      ld_year_q  <= load_year_i;
    end
  end

  assign cnt_gt1_o = amt_q > 16'd1;
  assign day_o     = day_q;
  assign month_o   = month_q;
  assign year_o    = year_q;

`ifndef SYNTHESIS
  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    month_q >= cda_pkg::MONTH_JAN && month_q <= cda_pkg::MONTH_DEC)
    else $error("month left 1..12");
  a_res_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q < cda_pkg::DIVISOR_YEAR) else $error("year residue out of range");
`endif

endmodule

FILE: hdl/cda_useq.sv
// Micro-sequencer: step counter, control store lookup and conditional branching.
module cda_useq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_fire_i,
  input  logic [1:0]        kind_i,
  input  cda_pkg::ustat_t   stat_i,
  output cda_pkg::uop_e     op_o,
  output logic              idle_o
);

  cda_pkg::upc_t   upc_q, upc_d;
  cda_pkg::uword_t uw;
  logic            take;

  assign uw = cda_pkg::urom(upc_q);

  always_comb begin
    case (uw.cond)
      cda_pkg::C_CNT_GT1:  take = stat_i.cnt_gt1;
      cda_pkg::C_DIV_MORE: take = stat_i.div_more;
      cda_pkg::C_OUT_FULL: take = stat_i.out_full;
      default:             take = 1'b0;
    endcase
  end

  always_comb begin
    upc_d = take ? uw.br : uw.nxt;
    if (uw.cond == cda_pkg::C_DISPATCH && in_fire_i) begin
      upc_d = cda_pkg::entry(cda_pkg::kind_e'(kind_i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= cda_pkg::UPC_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign op_o   = uw.op;
  assign idle_o = upc_q == cda_pkg::UPC_IDLE;

`ifndef SYNTHESIS
  a_fire_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i |=> upc_q != cda_pkg::UPC_IDLE) else $error("item accepted but no routine run");
  a_publish_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == cda_pkg::UPC_PUB && !stat_i.out_full) |=> upc_q == cda_pkg::UPC_IDLE)
    else $error("sequencer did not return to idle after publishing");
`endif

endmodule

FILE: hdl/calendar_date_adder.sv
// Top level: Gregorian date register with microcoded load and add-day/month/year operations.
//
//   beat      direction  handshake                  fields
//   input     in         in_valid_i / in_stall_o    kind, amount, load_day/month/year
//   result    out        out_valid_o / out_stall_i  day_out, month_out, year_out
//
// One item at a time; one result per item, held in an output register so the
// next item is taken while the result waits.
// The day loop steps one day per cycle, and the year-mod-400 and month/12
// reductions share one reciprocal-multiply divider. Reset gives 1 January of
// year 0; a stalled result holds until taken, and the next result waits in its
// publish step while the held result is stalled.
module calendar_date_adder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [15:0] amount_i,
  input  logic [4:0]  load_day_i,
  input  logic [3:0]  load_month_i,
  input  logic [15:0] load_year_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  day_out_o,
  output logic [3:0]  month_out_o,
  output logic [15:0] year_out_o
);

  logic               in_fire;
  logic               idle;
  cda_pkg::uop_e      op;
  cda_pkg::ustat_t    stat;
  cda_pkg::div_ctl_t  dctl;
  cda_pkg::div_t      dividend;
  cda_pkg::div_t      quot;
  cda_pkg::rem_t      rem;
  logic               div_more;
  logic               cnt_gt1;
  logic [4:0]         day;
  logic [3:0]         month;
  cda_pkg::year_t     year;
  logic               publish;

  logic               out_valid_q, out_valid_d;
  logic [4:0]         day_out_q;
  logic [3:0]         month_out_q;
  logic [15:0]        year_out_q;

  assign in_stall_o = !idle;
  assign in_fire    = in_valid_i && idle;

  assign stat.cnt_gt1  = cnt_gt1;
  assign stat.div_more = div_more;
  assign stat.out_full = out_valid_q && out_stall_i;

  assign dctl.start    = (op == cda_pkg::OP_DIV_MONTH) || (op == cda_pkg::OP_DIV_YEAR);
  assign dctl.step     = op == cda_pkg::OP_DIV_STEP;
  assign dctl.sel_year = op == cda_pkg::OP_DIV_YEAR;

  cda_useq u_useq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .kind_i    (kind_i),
    .stat_i    (stat),
    .op_o      (op),
    .idle_o    (idle)
  );

  cda_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_fire_i    (in_fire),
    .amount_i     (amount_i),
    .load_day_i   (load_day_i),
    .load_month_i (load_month_i),
    .load_year_i  (load_year_i),
    .op_i         (op),
    .quot_i       (quot),
    .rem_i        (rem),
    .dividend_o   (dividend),
    .cnt_gt1_o    (cnt_gt1),
    .day_o        (day),
    .month_o      (month),
    .year_o       (year)
  );

  cda_cdiv u_cdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (dctl),
    .dividend_i (dividend),
    .quot_o     (quot),
    .rem_o      (rem),
    .more_o     (div_more)
  );

  assign publish = (op == cda_pkg::OP_PUBLISH) && !stat.out_full;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (publish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (publish) begin
      day_out_q   <= day;
      month_out_q <= month;
      year_out_q  <= 16'(year);
    end
  end

  assign out_valid_o = out_valid_q;
  assign day_out_o   = day_out_q;
  assign month_out_o = month_out_q;
  assign year_out_o  = year_out_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !publish) else $error("result overwritten while stalled");
`endif

endmodule

FILE: tb/sv/calendar_date_adder_tb.sv
// Self-checking testbench for the calendar date adder: directed and random operations.
`timescale 1ns / 100ps

module calendar_date_adder_tb;

  localparam int QUIET_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
  } date_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  kind_i = '0;
  logic [15:0] amount_i = '0;
  logic [4:0]  load_day_i = '0;
  logic [3:0]  load_month_i = '0;
  logic [15:0] load_year_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [4:0]  day_out_o;
  logic [3:0]  month_out_o;
  logic [15:0] year_out_o;

  // Calendar held by the predictor, in step with the block's date register.
  logic [4:0]  cal_day = 5'd1;
  logic [3:0]  cal_month = 4'd1;
  logic [15:0] cal_year = 16'd0;

  date_t expected_dates[$];
  int    mismatch_count = 0;
  int    quiet_cycles = 0;
  int    sender_idle_pct = 0;
  int    receiver_stall_pct = 0;

  calendar_date_adder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .amount_i     (amount_i),
    .load_day_i   (load_day_i),
    .load_month_i (load_month_i),
    .load_year_i  (load_year_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .day_out_o    (day_out_o),
    .month_out_o  (month_out_o),
    .year_out_o   (year_out_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic bit is_leap_year(logic [15:0] y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic logic [4:0] days_in_month(logic [3:0] m, logic [15:0] y);
    logic [4:0] len;
    case (m)
      4'd2:                    len = is_leap_year(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // Applies one operation to the predicted calendar and returns the new date.
  function automatic date_t advance_calendar(cda_pkg::kind_e k, logic [15:0] amt,
                                             logic [4:0] ld, logic [3:0] lm,
                                             logic [15:0] ly);
    int unsigned months_total;
    case (k)
      cda_pkg::KIND_LOAD: begin
        cal_day = (ld == 5'd0) ? 5'd1 : ld;
        if (lm == 4'd0) cal_month = 4'd1;
        else if (lm > 4'd12) cal_month = 4'd12;
        else cal_month = lm;
        cal_year = ly;
      end
      cda_pkg::KIND_DAYS: begin
        for (int unsigned i = 0; i < amt; i++) begin
          // A day past the month's end (loaded that way) still rolls to the 1st.
          if (cal_day >= days_in_month(cal_month, cal_year)) begin
            cal_day = 5'd1;
            if (cal_month >= 4'd12) begin
              cal_month = 4'd1;
              cal_year = cal_year + 16'd1;
            end else begin
              cal_month = cal_month + 4'd1;
            end
          end else begin
            cal_day = cal_day + 5'd1;
          end
        end
      end
      cda_pkg::KIND_MONTHS: begin
        months_total = (int'(cal_month) - 1) + int'(amt);
        cal_month = 4'(months_total % 12 + 1);
        cal_year = 16'(cal_year + months_total / 12);
      end
      default: begin
        cal_year = cal_year + amt;
      end
    endcase
    return '{day: cal_day, month: cal_month, year: cal_year};
  endfunction

  // Presents one beat and returns at the edge that accepts it.
  task automatic send_item(input cda_pkg::kind_e k, input logic [15:0] amt,
                           input logic [4:0] ld, input logic [3:0] lm,
                           input logic [15:0] ly);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= k;
    amount_i     <= amt;
    load_day_i   <= ld;
    load_month_i <= lm;
    load_year_i  <= ly;
    do @(posedge clk_i); while (in_stall_o);
    expected_dates.push_back(advance_calendar(k, amt, ld, lm, ly));
  endtask

  task automatic check_reset_date;
    send_item(cda_pkg::KIND_DAYS, 16'd0, 5'd0, 4'd0, 16'd0);
    send_item(cda_pkg::KIND_MONTHS, 16'd0, 5'd0, 4'd0, 16'd0);
    send_item(cda_pkg::KIND_YEARS, 16'd0, 5'd0, 4'd0, 16'd0);
  endtask

  task automatic check_load_clamping;
    send_item(cda_pkg::KIND_LOAD, 16'd0, 5'd0, 4'd0, 16'd0);
    send_item(cda_pkg::KIND_LOAD, 16'hFFFF, 5'd31, 4'd15, 16'hFFFF);
    send_item(cda_pkg::KIND_LOAD, 16'd0, 5'd31, 4'd13, 16'd4);
    // Loading a day beyond the month's length keeps it as given.
    send_item(cda_pkg::KIND_LOAD, 16'd0, 5'd31, 4'd2, 16'd2023);
  endtask

  task automatic check_day_stepping;
    send_item(cda_pkg::KIND_DAYS, 16'd1, 5'd0, 4'd0, 16'd0);
    send_item(cda_pkg::KIND_LOAD, 16'd0, 5'd28, 4'd2, 16'd2000);
    send_item(cda_pkg::KIND_DAYS, 16'd1, 5'd0, 4'd0, 16'd0);
    send_item(cda_pkg::KIND_DAYS, 16'd1, 5'd0, 4'd0, 16'd0);
    send_item(cda_pkg::KIND_LOAD, 16'd0, 5'd28, 4'd2, 16'd1900);
    send_item(cda_pkg::KIND_DAYS, 16'd1, 5'd0, 4'd0, 16'd0);
    send_item(cda_pkg::KIND_LOAD, 16'd0, 5'd31, 4'd12, 16'hFFFF);
    send_item(cda_pkg::KIND_DAYS, 16'd60, 5'd0, 4'd0, 16'd0);
    send_item(cda_pkg::KIND_LOAD, 16'd0, 5'd1, 4'd1, 16'd0);
    send_item(cda_pkg::KIND_DAYS, 16'hFFFF, 5'd0, 4'd0, 16'd0);
  endtask

  task automatic check_month_carry;
    send_item(cda_pkg::KIND_LOAD, 16'd0, 5'd31, 4'd12, 16'd2020);
    // Twelve months from December must land on December, never month zero.
    send_item(cda_pkg::KIND_MONTHS, 16'd12, 5'd0, 4'd0, 16'd0);
    send_item(cda_pkg::KIND_LOAD, 16'd0, 5'd31, 4'd1, 16'd2021);
    send_item(cda_pkg::KIND_MONTHS, 16'd1, 5'd0, 4'd0, 16'd0);
    send_item(cda_pkg::KIND_DAYS, 16'd1, 5'd0, 4'd0, 16'd0);
    send_item(cda_pkg::KIND_MONTHS, 16'hFFFF, 5'd0, 4'd0, 16'd0);
  endtask

  task automatic check_year_wrap;
    send_item(cda_pkg::KIND_YEARS, 16'hFFFF, 5'd0, 4'd0, 16'd0);
    send_item(cda_pkg::KIND_YEARS, 16'd1, 5'd0, 4'd0, 16'd0);
  endtask

  task automatic run_random_mix(input int idle_pct, input int stall_pct, input int count);
    cda_pkg::kind_e k;
    logic [15:0]    amt;
    logic [4:0]     ld;
    logic [3:0]     lm;
    logic [15:0]    ly;
    int             pick;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      k    = cda_pkg::kind_e'($urandom_range(3));
      ld   = $urandom_range(1) ? 5'($urandom_range(25, 31)) : 5'($urandom_range(31));
      lm   = 4'($urandom_range(15));
      // Half the loads sit near century years to exercise the leap rule.
      ly   = $urandom_range(1) ? 16'($urandom)
                               : 16'($urandom_range(655) * 100 + $urandom_range(4));
      pick = $urandom_range(99);
      if (k == cda_pkg::KIND_DAYS) begin
        if (pick == 0) amt = 16'($urandom_range(3000));
        else if (pick < 30) amt = 16'($urandom_range(400));
        else amt = 16'($urandom_range(40));
      end else begin
        amt = (pick < 50) ? 16'($urandom) : 16'($urandom_range(30));
      end
      send_item(k, amt, ld, lm, ly);
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= (receiver_stall_pct > 0) && ($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  always @(posedge clk_i) begin
    date_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_dates.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: %0d/%0d/%0d", day_out_o, month_out_o,
                   year_out_o);
      end else begin
        want = expected_dates.pop_front();
        if (day_out_o !== want.day || month_out_o !== want.month ||
            year_out_o !== want.year) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("date mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     want.day, want.month, want.year, day_out_o, month_out_o, year_out_o);
        end
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_reset_date();
    check_load_clamping();
    check_day_stepping();
    check_month_carry();
    check_year_wrap();
    run_random_mix(0, 0, 200);
    run_random_mix(76, 0, 200);
    run_random_mix(0, 76, 200);
    run_random_mix(27, 27, 200);
    in_valid_i <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_dates.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/cda_pkg.sv
hdl/cda_cdiv.sv
hdl/cda_dpath.sv
hdl/cda_useq.sv
hdl/calendar_date_adder.sv
tb/sv/calendar_date_adder_tb.sv
